[design/two_way_lru_cache_tag_lookup_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-way LRU tag lookup
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_LRU_CACHE_TAG_LOOKUP_TOP_ASSERT_SVH
`define TWO_WAY_LRU_CACHE_TAG_LOOKUP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset
`define TLRU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tlru assertion failed");
// Check a property on every rising edge, reset included
`define TLRU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tlru assertion failed");
`else
`define TLRU_ASSERT(label, clk, rst_n, prop)
`define TLRU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[design/tlru_pkg.sv]
// ----------------------------------------------------------------------------
// tlru_pkg
// Address split constants and controller command type for the tag lookup.
// ----------------------------------------------------------------------------
package tlru_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int OFFSET_BITS = 5;
  localparam int SET_BITS    = 6;
  localparam int NUM_SETS    = 1 << SET_BITS;
  localparam int BLOCK_BITS  = ADDR_BITS - OFFSET_BITS;
  localparam int TAG_BITS    = BLOCK_BITS - SET_BITS;
  localparam int CNT_BITS    = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture address and start the tag read
    logic commit;  // resolve lookup, update state, load the result beat
  } tlru_cmd_t;

endpackage

[design/tlru_ram.sv]
// ----------------------------------------------------------------------------
// tlru_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/tlru_ctrl.sv]
// ----------------------------------------------------------------------------
// tlru_ctrl
// Lookup sequencer: accepts an address, waits for the tag read, commits the
// result into the output register when it is free.
// ----------------------------------------------------------------------------
`include "two_way_lru_cache_tag_lookup_top_assert.svh"

module tlru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output tlru_pkg::tlru_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // Output register is free when empty or drained this cycle
  assign slot_free  = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit = (state_r == ST_LOOK) && slot_free;

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Fill the output beat on commit, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  `TLRU_ASSERT(a_load_then_look, clk, rst_n, cmd.load |=> state_r == ST_LOOK)
  `TLRU_ASSERT(a_commit_slot_free, clk, rst_n, cmd.commit |-> (!out_valid_r || !out_stall))
  `TLRU_ASSERT(a_beat_from_commit, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.commit))
  `TLRU_ASSERT_ALWAYS(a_no_load_and_commit, clk, !(cmd.load && cmd.commit))

endmodule

[design/tlru_dp.sv]
// ----------------------------------------------------------------------------
// tlru_dp
// Tag lookup datapath: per-way tag RAMs, valid and LRU bits, hit and miss
// counters, and the result register.
// ----------------------------------------------------------------------------
module tlru_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tlru_pkg::tlru_cmd_t                  cmd,
  input  logic [tlru_pkg::ADDR_BITS-1:0]       in_address,
  output logic [tlru_pkg::OFFSET_BITS-1:0]     out_byte_offset,
  output logic [tlru_pkg::BLOCK_BITS-1:0]      out_block_number,
  output logic [tlru_pkg::SET_BITS-1:0]        out_set_index,
  output logic                                 out_way,
  output logic [tlru_pkg::TAG_BITS-1:0]        out_tag,
  output logic                                 out_miss,
  output logic                                 out_replaced_valid,
  output logic [tlru_pkg::TAG_BITS-1:0]        out_evicted_tag,
  output logic [tlru_pkg::CNT_BITS-1:0]        out_hit_count,
  output logic [tlru_pkg::CNT_BITS-1:0]        out_miss_count
);

  localparam int OB = tlru_pkg::OFFSET_BITS;
  localparam int SB = tlru_pkg::SET_BITS;
  localparam int TB = tlru_pkg::TAG_BITS;
  localparam int BB = tlru_pkg::BLOCK_BITS;
  localparam int CB = tlru_pkg::CNT_BITS;
  localparam int NS = tlru_pkg::NUM_SETS;

  logic [tlru_pkg::ADDR_BITS-1:0] addr_r;
  logic [NS-1:0]                  valid0_r, valid1_r, lru_r;
  logic [CB-1:0]                  hits_r, misses_r;

  logic [SB-1:0] set_idx;
  logic [TB-1:0] tag;
  logic [TB-1:0] rd0, rd1;
  logic          v0, v1, hit0, hit1, miss, way, replaced;
  logic [TB-1:0] evicted;
  logic          we0, we1;

  // Split the held address
  assign set_idx = addr_r[OB +: SB];
  assign tag     = addr_r[OB + SB +: TB];

  // Capture the address at accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_address;
    end
  end

  // One tag RAM per way, both read at the set of the incoming address
  tlru_ram #(.WIDTH(TB), .DEPTH(NS)) u_tag_way0 (
    .clk   (clk),
    .we    (we0),
    .waddr (set_idx),
    .wdata (tag),
    .re    (cmd.load),
    .raddr (in_address[OB +: SB]),
    .rdata (rd0)
  );

  tlru_ram #(.WIDTH(TB), .DEPTH(NS)) u_tag_way1 (
    .clk   (clk),
    .we    (we1),
    .waddr (set_idx),
    .wdata (tag),
    .re    (cmd.load),
    .raddr (in_address[OB +: SB]),
    .rdata (rd1)
  );

  // Compare both ways and pick the victim on a miss
  always_comb begin
    v0   = valid0_r[set_idx];
    v1   = valid1_r[set_idx];
    hit0 = v0 && (rd0 == tag);
    hit1 = v1 && (rd1 == tag);
    miss = !hit0 && !hit1;
    if (hit0) begin
      way = 1'b0;
    end else if (hit1) begin
      way = 1'b1;
    end else if (!v0) begin
      way = 1'b0;
    end else if (!v1) begin
      way = 1'b1;
    end else begin
      way = lru_r[set_idx];
    end
    replaced = miss && v0 && v1;
    if (replaced) begin
      evicted = way ? rd1 : rd0;
    end else begin
      evicted = '0;
    end
  end

  assign we0 = cmd.commit && miss && !way;
  assign we1 = cmd.commit && miss && way;

  // Update valid, LRU and counters on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= '0;
      valid1_r <= '0;
      lru_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      if (we0) begin
        valid0_r[set_idx] <= 1'b1;
      end
      if (we1) begin
        valid1_r[set_idx] <= 1'b1;
      end
      lru_r[set_idx] <= !way;
      if (miss) begin
        misses_r <= misses_r + CB'(1);
      end else begin
        hits_r <= hits_r + CB'(1);
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_byte_offset    <= addr_r[OB-1:0];
      out_block_number   <= addr_r[OB +: BB];
      out_set_index      <= set_idx;
      out_way            <= way;
      out_tag            <= tag;
      out_miss           <= miss;
      out_replaced_valid <= replaced;
      out_evicted_tag    <= evicted;
      out_hit_count      <= miss ? hits_r : hits_r + CB'(1);
      out_miss_count     <= miss ? misses_r + CB'(1) : misses_r;
    end
  end

endmodule

[design/two_way_lru_cache_tag_lookup_top.sv]
// A result beat is valid once its address has been through the look state and
// committed, or later while the previous beat still waits in the output register.
// A new address is refused until the previous one has passed the registered read
// of the per-way tag RAMs and the compare and update step.
// A finished beat waits in the output register while the next address enters.
// Reset (synchronous, active low) clears valid bits, LRU bits and counters at
// once; the tag RAMs are not cleared and no address is refused after reset.
// ----------------------------------------------------------------------------
// two_way_lru_cache_tag_lookup_top
// Two-way set-associative tag lookup with LRU replacement and hit/miss counts.
// ----------------------------------------------------------------------------
module two_way_lru_cache_tag_lookup_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tlru_pkg::ADDR_BITS-1:0]       in_address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tlru_pkg::OFFSET_BITS-1:0]     out_byte_offset,
  output logic [tlru_pkg::BLOCK_BITS-1:0]      out_block_number,
  output logic [tlru_pkg::SET_BITS-1:0]        out_set_index,
  output logic                                 out_way,
  output logic [tlru_pkg::TAG_BITS-1:0]        out_tag,
  output logic                                 out_miss,
  output logic                                 out_replaced_valid,
  output logic [tlru_pkg::TAG_BITS-1:0]        out_evicted_tag,
  output logic [tlru_pkg::CNT_BITS-1:0]        out_hit_count,
  output logic [tlru_pkg::CNT_BITS-1:0]        out_miss_count
);

  tlru_pkg::tlru_cmd_t cmd;

  // Sequencer
  tlru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Lookup datapath
  tlru_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_address         (in_address),
    .out_byte_offset    (out_byte_offset),
    .out_block_number   (out_block_number),
    .out_set_index      (out_set_index),
    .out_way            (out_way),
    .out_tag            (out_tag),
    .out_miss           (out_miss),
    .out_replaced_valid (out_replaced_valid),
    .out_evicted_tag    (out_evicted_tag),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count)
  );

endmodule

[sim/two_way_lru_cache_tag_lookup_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-way LRU tag lookup testbench
// Feeds byte addresses into the lookup and checks each result beat against
// a cycle-free model of the tag store, valid bits, LRU bits and counters.
// A directed opening covers fills, hits in both ways and evictions; random
// traffic then mixes hot sets with few tags and fully random addresses,
// under random idling on both sides and one long hold on the result side.
// ----------------------------------------------------------------------------
module two_way_lru_cache_tag_lookup_top_tb;

  localparam int ADDR_BITS   = tlru_pkg::ADDR_BITS;
  localparam int OFFSET_BITS = tlru_pkg::OFFSET_BITS;
  localparam int SET_BITS    = tlru_pkg::SET_BITS;
  localparam int NUM_SETS    = tlru_pkg::NUM_SETS;
  localparam int BLOCK_BITS  = tlru_pkg::BLOCK_BITS;
  localparam int TAG_BITS    = tlru_pkg::TAG_BITS;
  localparam int CNT_BITS    = tlru_pkg::CNT_BITS;

  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [BLOCK_BITS-1:0]  block_number;
    logic [SET_BITS-1:0]    set_index;
    logic                   way;
    logic [TAG_BITS-1:0]    tag;
    logic                   miss;
    logic                   replaced_valid;
    logic [TAG_BITS-1:0]    evicted_tag;
    logic [CNT_BITS-1:0]    hit_count;
    logic [CNT_BITS-1:0]    miss_count;
  } lookup_beat_t;

  // Tracks the cache state and holds the lookups still owed by the block
  class lru_lookup_checker;
    logic [TAG_BITS-1:0] tag_ram [2][NUM_SETS];
    bit                  line_ok [2][NUM_SETS];
    bit                  lru_way [NUM_SETS];
    logic [CNT_BITS-1:0] hit_total;
    logic [CNT_BITS-1:0] miss_total;
    int                  evictions;
    int                  errors;
    lookup_beat_t        pending_lookups [$];

    function new();
      foreach (line_ok[w, s]) begin
        line_ok[w][s] = 1'b0;
        tag_ram[w][s] = '0;
      end
      foreach (lru_way[s]) lru_way[s] = 1'b0;
      hit_total  = '0;
      miss_total = '0;
      evictions  = 0;
      errors     = 0;
    endfunction

    // Look up one accepted address, update the state and queue the beat
    function void predict_lookup(logic [ADDR_BITS-1:0] addr);
      lookup_beat_t          b;
      logic [BLOCK_BITS-1:0] blk;
      logic [SET_BITS-1:0]   s;
      logic [TAG_BITS-1:0]   t;
      bit                    hit0;
      bit                    hit1;
      blk = addr[ADDR_BITS-1:OFFSET_BITS];
      s   = blk[SET_BITS-1:0];
      t   = blk[BLOCK_BITS-1:SET_BITS];
      b   = '0;
      b.byte_offset  = addr[OFFSET_BITS-1:0];
      b.block_number = blk;
      b.set_index    = s;
      b.tag          = t;
      hit0 = line_ok[0][s] && (tag_ram[0][s] == t);
      hit1 = line_ok[1][s] && (tag_ram[1][s] == t);
      if (hit0 || hit1) begin
        b.way = hit0 ? 1'b0 : 1'b1;
        hit_total = hit_total + CNT_BITS'(1);
      end else begin
        // Fill an empty way first, else evict the older line
        b.miss = 1'b1;
        if (!line_ok[0][s]) begin
          b.way = 1'b0;
        end else if (!line_ok[1][s]) begin
          b.way = 1'b1;
        end else begin
          b.way            = lru_way[s];
          b.replaced_valid = 1'b1;
          b.evicted_tag    = tag_ram[b.way][s];
          evictions++;
        end
        tag_ram[b.way][s] = t;
        line_ok[b.way][s] = 1'b1;
        miss_total = miss_total + CNT_BITS'(1);
      end
      lru_way[s]   = ~b.way;
      b.hit_count  = hit_total;
      b.miss_count = miss_total;
      pending_lookups.push_back(b);
    endfunction

    function void compare_field(string name, logic [CNT_BITS-1:0] exp_v,
                                logic [CNT_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest queued lookup
    function void check_beat(lookup_beat_t got);
      lookup_beat_t exp_b;
      if (pending_lookups.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, got);
        errors++;
        return;
      end
      exp_b = pending_lookups.pop_front();
      compare_field("byte_offset", CNT_BITS'(exp_b.byte_offset),
                    CNT_BITS'(got.byte_offset));
      compare_field("block_number", CNT_BITS'(exp_b.block_number),
                    CNT_BITS'(got.block_number));
      compare_field("set_index", CNT_BITS'(exp_b.set_index), CNT_BITS'(got.set_index));
      compare_field("way", CNT_BITS'(exp_b.way), CNT_BITS'(got.way));
      compare_field("tag", CNT_BITS'(exp_b.tag), CNT_BITS'(got.tag));
      compare_field("miss", CNT_BITS'(exp_b.miss), CNT_BITS'(got.miss));
      compare_field("replaced_valid", CNT_BITS'(exp_b.replaced_valid),
                    CNT_BITS'(got.replaced_valid));
      compare_field("evicted_tag", CNT_BITS'(exp_b.evicted_tag),
                    CNT_BITS'(got.evicted_tag));
      compare_field("hit_count", exp_b.hit_count, got.hit_count);
      compare_field("miss_count", exp_b.miss_count, got.miss_count);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [ADDR_BITS-1:0]   in_address;
  logic                   out_valid;
  logic                   out_stall;
  logic [OFFSET_BITS-1:0] out_byte_offset;
  logic [BLOCK_BITS-1:0]  out_block_number;
  logic [SET_BITS-1:0]    out_set_index;
  logic                   out_way;
  logic [TAG_BITS-1:0]    out_tag;
  logic                   out_miss;
  logic                   out_replaced_valid;
  logic [TAG_BITS-1:0]    out_evicted_tag;
  logic [CNT_BITS-1:0]    out_hit_count;
  logic [CNT_BITS-1:0]    out_miss_count;

  lru_lookup_checker lookups = new();
  bit                quiet_tail   = 1'b0;
  bit                hold_request = 1'b0;
  int                sent_total   = 0;
  int                cycle_count  = 0;

  two_way_lru_cache_tag_lookup_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_offset    (out_byte_offset),
    .out_block_number   (out_block_number),
    .out_set_index      (out_set_index),
    .out_way            (out_way),
    .out_tag            (out_tag),
    .out_miss           (out_miss),
    .out_replaced_valid (out_replaced_valid),
    .out_evicted_tag    (out_evicted_tag),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watch both channels; check results before noting new addresses
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        lookups.check_beat({out_byte_offset, out_block_number, out_set_index, out_way,
                            out_tag, out_miss, out_replaced_valid, out_evicted_tag,
                            out_hit_count, out_miss_count});
      end
      if (in_valid && !in_stall) begin
        lookups.predict_lookup(in_address);
      end
    end
  end

  // Result side: random stall bursts, one long hold on request, none at the tail
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d lookups pending", cycle_count,
             lookups.pending_lookups.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [ADDR_BITS-1:0] mk_addr(logic [TAG_BITS-1:0] t,
                                                   logic [SET_BITS-1:0] s,
                                                   logic [OFFSET_BITS-1:0] off);
    return {t, s, off};
  endfunction

  // Offer one address and hold it until the block takes the beat
  task automatic offer_address(logic [ADDR_BITS-1:0] addr);
    in_valid   <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    // Drop valid for a random gap now and then
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  initial begin
    logic [SET_BITS-1:0] hot_sets [4];
    logic [TAG_BITS-1:0] hot_tags [3];
    logic [TAG_BITS-1:0] tag_max;

    tag_max    = '1;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_address <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fills into empty ways, hits in both ways, evictions driven by LRU
    offer_address(32'h0000_0000);
    offer_address(32'hFFFF_FFFF);
    offer_address(mk_addr(21'd0, 6'd0, 5'd31));
    offer_address(mk_addr(21'd1, 6'd0, 5'd0));
    offer_address(mk_addr(21'd1, 6'd0, 5'd5));
    offer_address(mk_addr(21'd0, 6'd0, 5'd9));
    offer_address(mk_addr(21'd2, 6'd0, 5'd0));
    offer_address(mk_addr(21'd1, 6'd0, 5'd1));
    offer_address(mk_addr(21'd2, 6'd0, 5'd2));
    offer_address(mk_addr(tag_max, 6'd63, 5'd0));
    offer_address(mk_addr(21'h155555, 6'd63, 5'd17));
    offer_address(mk_addr(21'h0AAAAA, 6'd63, 5'd10));
    offer_address(mk_addr(21'h0AAAAA, 6'd63, 5'd21));
    offer_address(32'h8000_0000);
    offer_address(32'hAAAA_AAAA);
    offer_address(32'h5555_5555);
    offer_address(32'h5555_5555);
    offer_address(mk_addr(21'h155555, 6'd63, 5'd0));

    // Mostly hot sets with three tags each, the rest fully random
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        foreach (hot_sets[k]) hot_sets[k] = SET_BITS'($urandom_range(0, NUM_SETS - 1));
        foreach (hot_tags[k]) hot_tags[k] = TAG_BITS'($urandom);
      end
      if (i == 300) hold_request = 1'b1;
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        offer_address(mk_addr(hot_tags[$urandom_range(0, 2)],
                              hot_sets[$urandom_range(0, 3)],
                              OFFSET_BITS'($urandom_range(0, 31))));
      end else begin
        offer_address($urandom);
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding lookups
    while (lookups.pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d lookups: %0d hits, %0d misses, %0d of them evicting a valid line",
             sent_total, lookups.hit_total, lookups.miss_total, lookups.evictions);
    $display("Mismatches found: %0d", lookups.errors);
    if (lookups.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
